@@ hdl/tgt_pkg.sv @@
// Shared types, widths and constants of the twiddle gain tuner.
// No dependencies; every other file of the tuner except tgt_queue uses this package.
package tgt_pkg;

  localparam int ERR_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 42;
  localparam int TL_W       = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 1;
  localparam int QUEUE_DEPTH = 4;

  // Step scaling divides by ten: the dividend is halved, then multiplied by
  // the reciprocal of five, which is exact for every 32-bit value.
  localparam int DIV_N_W = GAIN_W + 1;
  localparam logic [GAIN_W-1:0] RECIP5 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 34;
  localparam logic [GAIN_W:0] CEIL_BIAS = 33'd9;

  localparam logic [TL_W-1:0] TL_RESET = 12'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_TRIAL_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_KP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_KI      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_KD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_P  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_I  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_D  = 3'd6;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_INC,
    PH_DEC
  } phase_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_DIV,
    BS_STEP,
    BS_START,
    BS_EMIT
  } bstate_t;

  typedef enum logic [1:0] {
    SM_NONE,
    SM_GROW,
    SM_SHRINK
  } step_mode_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [SUM_W-1:0]  trial_error;
    logic              improved;
  } result_t;

  // Starting gains and steps after reset; gains beyond the third start at zero.
  function automatic logic [GAIN_W-1:0] init_gain(input int g);
    logic [GAIN_W-1:0] v;
    case (g)
      0: v = 32'd4194304;
      1: v = 32'd83886;
      2: v = 32'd67108864;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] init_step(input int g);
    logic [GAIN_W-1:0] v;
    case (g)
      0: v = 32'd167772;
      1: v = 32'd1678;
      2: v = 32'd1677722;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/tgt_front.sv @@
// Front end: takes error words, squares them and sums each trial.
// Depends on tgt_pkg; pushes finished trial sums into tgt_queue.
module tgt_front #(
  parameter int COUNT_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tgt_pkg::ERR_W-1:0]   in_sample,
  input  tgt_pkg::cfg_wr_t            cfg,
  input  logic                        q_full,
  output logic                        push,
  output logic [tgt_pkg::SUM_W-1:0]   push_sum
);

  logic [tgt_pkg::TL_W-1:0]  tl_r;
  logic [COUNT_BITS-1:0]     cnt_r, cnt_inc, tl_cmp;
  logic                      last_in, accept, stall;
  logic [tgt_pkg::ERR_W-1:0] mag_in;

  logic                      s1_v_r, s1_last_r;
  logic [tgt_pkg::ERR_W-1:0] s1_mag_r;
  logic                      s2_v_r, s2_last_r;
  logic [tgt_pkg::SQ_W-1:0]  s2_sq_r;
  logic [tgt_pkg::SUM_W-1:0] acc_r;
  logic [tgt_pkg::SUM_W:0]   sum_add;
  logic [tgt_pkg::SUM_W-1:0] sum_sat;

  assign tl_cmp  = COUNT_BITS'(tl_r);
  assign cnt_inc = cnt_r + 1'b1;
  assign last_in = (cnt_inc == tl_cmp);
  // The whole pipe holds only when a finished sum finds the queue full.
  assign stall    = s2_v_r & s2_last_r & q_full;
  assign in_ready = ~stall;
  assign accept   = in_valid & in_ready;
  assign mag_in   = in_sample[tgt_pkg::ERR_W-1] ? (~in_sample + 1'b1) : in_sample;

  assign sum_add  = {1'b0, acc_r} + {{(tgt_pkg::SUM_W - tgt_pkg::SQ_W + 1){1'b0}}, s2_sq_r};
  assign sum_sat  = sum_add[tgt_pkg::SUM_W] ? {tgt_pkg::SUM_W{1'b1}}
                                             : sum_add[tgt_pkg::SUM_W-1:0];
  assign push     = s2_v_r & s2_last_r & ~q_full;
  assign push_sum = sum_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r   <= tgt_pkg::TL_RESET;
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      if (cfg.valid && cfg.index == tgt_pkg::REG_TRIAL_LENGTH) begin
        tl_r <= cfg.data[tgt_pkg::TL_W-1:0];
      end
      if (accept) begin
        cnt_r <= last_in ? '0 : cnt_inc;
      end
      if (!stall) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
        if (s2_v_r) begin
          acc_r <= s2_last_r ? '0 : sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_mag_r  <= mag_in;
      s1_last_r <= last_in;
      s2_sq_r   <= s1_mag_r * s1_mag_r;
      s2_last_r <= s1_last_r;
    end
  end

endmodule

@@ hdl/tgt_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
// Depends on nothing; width and depth come from the instantiating module.
module tgt_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == (AW + 1)'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/tgt_back.sv @@
// Back end: runs the twiddle step on each finished trial sum and holds the
// result word in the output register. Depends on tgt_pkg.
module tgt_back #(
  parameter int NUM_GAINS = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tgt_pkg::cfg_wr_t          cfg,
  input  logic                      q_valid,
  input  logic [tgt_pkg::SUM_W-1:0] q_sum,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tgt_pkg::result_t          res
);

  localparam int GI_W = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int GW   = tgt_pkg::GAIN_W;

  tgt_pkg::bstate_t    state_r, state_nxt;
  tgt_pkg::phase_t     phase_r, tgt_phase_r;
  tgt_pkg::step_mode_t mode_r;

  logic [GW-1:0]  best_r  [NUM_GAINS];
  logic [GW-1:0]  trial_r [NUM_GAINS];
  logic [GW-1:0]  step_r  [NUM_GAINS];
  logic [GW-1:0]  gsel    [3];
  logic [GI_W-1:0] gi_r, gi_adv, idx;

  logic [tgt_pkg::SUM_W-1:0] sum_r, best_sum_r;
  logic                      improved_r;
  logic                      first_case, better_case, need_div;

  logic [tgt_pkg::DIV_N_W-1:0] div_n;
  logic [GW-1:0]               div_h_r;
  logic [2*GW-1:0]             div_prod_r;
  logic [GW-1:0]               div_q;

  logic [GW-1:0] step_cur, best_idx, step_idx;
  logic [GW:0]   grown, inc_sum;
  logic [GW-1:0] dec_val, trial_new;

  logic div_load, div_run, step_wr, trial_load, out_load;
  logic out_valid_r;
  tgt_pkg::result_t res_r;

  assign gi_adv = (gi_r == GI_W'(NUM_GAINS - 1)) ? '0 : gi_r + 1'b1;
  assign idx    = (tgt_phase_r == tgt_pkg::PH_INC) ? gi_adv : gi_r;

  // A phase other than increase or decrease behaves like the first trial.
  assign first_case  = (phase_r != tgt_pkg::PH_INC) && (phase_r != tgt_pkg::PH_DEC);
  assign better_case = !first_case && (best_sum_r > q_sum);
  assign need_div    = !first_case && (better_case || phase_r == tgt_pkg::PH_DEC);

  assign step_cur = step_r[gi_r];
  assign best_idx = best_r[idx];
  assign step_idx = step_r[idx];
  assign div_q    = GW'(div_prod_r >> tgt_pkg::RECIP_SHIFT);
  assign grown    = {1'b0, step_cur} + {1'b0, div_q};
  assign inc_sum  = {1'b0, best_idx} + {1'b0, step_idx};
  assign dec_val  = (best_idx > step_idx) ? best_idx - step_idx : '0;
  assign trial_new = (tgt_phase_r == tgt_pkg::PH_INC)
                   ? (inc_sum[GW] ? {GW{1'b1}} : inc_sum[GW-1:0]) : dec_val;

  // Growth needs floor(step/10), shrink needs ceil(step/10).
  assign div_n = better_case ? {1'b0, step_cur} : {1'b0, step_cur} + tgt_pkg::CEIL_BIAS;

  for (genvar g = 0; g < 3; g++) begin : g_out
    if (g < NUM_GAINS) begin : g_has
      assign gsel[g] = trial_r[g];
    end else begin : g_none
      assign gsel[g] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgt_pkg::BS_IDLE: begin
        if (q_valid) begin
          state_nxt = need_div ? tgt_pkg::BS_DIV : tgt_pkg::BS_START;
        end
      end
      tgt_pkg::BS_DIV:   state_nxt = tgt_pkg::BS_STEP;
      tgt_pkg::BS_STEP:  state_nxt = tgt_pkg::BS_START;
      tgt_pkg::BS_START: state_nxt = tgt_pkg::BS_EMIT;
      tgt_pkg::BS_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = tgt_pkg::BS_IDLE;
        end
      end
      default: state_nxt = tgt_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    div_load   = 1'b0;
    div_run    = 1'b0;
    step_wr    = 1'b0;
    trial_load = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      tgt_pkg::BS_IDLE: begin
        q_pop    = q_valid;
        div_load = q_valid;
      end
      tgt_pkg::BS_DIV:   div_run    = 1'b1;
      tgt_pkg::BS_STEP:  step_wr    = 1'b1;
      tgt_pkg::BS_START: trial_load = 1'b1;
      tgt_pkg::BS_EMIT:  out_load   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tgt_pkg::BS_IDLE;
      phase_r     <= tgt_pkg::PH_FIRST;
      tgt_phase_r <= tgt_pkg::PH_INC;
      mode_r      <= tgt_pkg::SM_NONE;
      gi_r        <= '0;
      best_sum_r  <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < NUM_GAINS; g++) begin
        best_r[g]  <= tgt_pkg::init_gain(g);
        trial_r[g] <= tgt_pkg::init_gain(g);
        step_r[g]  <= tgt_pkg::init_step(g);
      end
    end else begin
      state_r <= state_nxt;

      // Starting values written during the first trial go straight into the state.
      if (cfg.valid && phase_r == tgt_pkg::PH_FIRST) begin
        for (int g = 0; g < NUM_GAINS; g++) begin
          if (g < 3 && cfg.index == tgt_pkg::CFG_IDX_W'(int'(tgt_pkg::REG_INIT_KP) + g)) begin
            best_r[g]  <= cfg.data;
            trial_r[g] <= cfg.data;
          end
          if (g < 3 && cfg.index == tgt_pkg::CFG_IDX_W'(int'(tgt_pkg::REG_INIT_STEP_P) + g)) begin
            step_r[g] <= cfg.data;
          end
        end
      end

      if (q_pop) begin
        if (first_case) begin
          gi_r        <= '0;
          best_sum_r  <= q_sum;
          tgt_phase_r <= tgt_pkg::PH_INC;
          mode_r      <= tgt_pkg::SM_NONE;
        end else if (better_case) begin
          for (int g = 0; g < NUM_GAINS; g++) begin
            best_r[g] <= trial_r[g];
          end
          best_sum_r  <= q_sum;
          tgt_phase_r <= tgt_pkg::PH_INC;
          mode_r      <= tgt_pkg::SM_GROW;
        end else if (phase_r == tgt_pkg::PH_INC) begin
          tgt_phase_r <= tgt_pkg::PH_DEC;
          mode_r      <= tgt_pkg::SM_NONE;
        end else begin
          tgt_phase_r <= tgt_pkg::PH_INC;
          mode_r      <= tgt_pkg::SM_SHRINK;
        end
      end

      if (step_wr) begin
        case (mode_r)
          tgt_pkg::SM_GROW:
            step_r[gi_r] <= grown[GW] ? {GW{1'b1}} : grown[GW-1:0];
          tgt_pkg::SM_SHRINK:
            step_r[gi_r] <= step_cur - div_q;
          default: ;
        endcase
      end

      if (trial_load) begin
        for (int g = 0; g < NUM_GAINS; g++) begin
          if (GI_W'(g) == idx) begin
            trial_r[g] <= trial_new;
          end else begin
            trial_r[g] <= best_r[g];
          end
        end
        gi_r    <= idx;
        phase_r <= tgt_phase_r;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Division datapath and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_r      <= q_sum;
      improved_r <= first_case || better_case;
    end
    if (div_load) begin
      div_h_r <= div_n[GW:1];
    end
    if (div_run) begin
      div_prod_r <= div_h_r * tgt_pkg::RECIP5;
    end
    if (out_load) begin
      res_r.gain_p      <= gsel[0];
      res_r.gain_i      <= gsel[1];
      res_r.gain_d      <= gsel[2];
      res_r.trial_error <= sum_r;
      res_r.improved    <= improved_r;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ hdl/twiddle_gain_tuner.sv @@
// Top level of the twiddle gain tuner: front end, trial queue and back end.
// Depends on tgt_pkg, tgt_front, tgt_queue and tgt_back.
//
//  Channel   Direction  Word contents
//  in_       slave      tdata[15:0] error_sample (signed Q8.8)
//  out_      master     tdata: gain_p, gain_i, gain_d, trial_error; tuser: improved
//  cfg_      slave      cfg_index selects register, cfg_data carries its value
//
// The front end takes one error word per cycle unless stalled; a finished trial sum
// passes the magnitude and square registers, then enters a four-entry queue, so the
// front end can take the next trial's words while the back end works. The back end
// steps through idle, start and emit states for a trial, and also through divide
// and step states when a step grows or shrinks (a registered multiply of the halved
// step by the reciprocal of five). Input stalls only when a finished sum finds the
// queue full; the output register holds a result word while the consumer stalls.
// Reset is synchronous and needs no clearing pass.
module twiddle_gain_tuner #(
  parameter int NUM_GAINS  = 3,
  parameter int COUNT_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tgt_pkg::ERR_W-1:0]         in_tdata,   // [15:0] error_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] gain_p, [63:32] gain_i, [95:64] gain_d, [137:96] trial_error, rest zero
  output logic [tgt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [tgt_pkg::OUT_USER_W-1:0]    out_tuser,  // [0] improved
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tgt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PAD_W = tgt_pkg::OUT_DATA_W - 3 * tgt_pkg::GAIN_W - tgt_pkg::SUM_W;

  tgt_pkg::cfg_wr_t          cfg;
  tgt_pkg::result_t          res;
  logic                      q_full, q_nonempty, q_push, q_pop;
  logic [tgt_pkg::SUM_W-1:0] q_push_sum, q_head;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tgt_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_sample(in_tdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (q_push),
    .push_sum (q_push_sum)
  );

  tgt_queue #(
    .WIDTH(tgt_pkg::SUM_W),
    .DEPTH(tgt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_sum),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  tgt_back #(
    .NUM_GAINS(NUM_GAINS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_nonempty),
    .q_sum    (q_head),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res.trial_error, res.gain_d, res.gain_i, res.gain_p};
  assign out_tuser = res.improved;

endmodule

@@ hdl/tgt_checker.sv @@
// Port-level checks of the twiddle gain tuner, bound to its top level.
// Depends on tgt_pkg and twiddle_gain_tuner.
module tgt_port_assert (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tgt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tgt_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           cfg_ready
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind twiddle_gain_tuner tgt_port_assert u_tgt_port_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_ready (cfg_ready)
);

@@ dv/tgt_checker.sv @@
`timescale 1ns / 100ps
// Checker for the twiddle gain tuner: watches the error, result and register channels,
// keeps its own copy of the tuner state and compares every result word field by field.
// Depends on tgt_pkg for widths, register indexes, the phase type and the result layout.
module tgt_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tgt_pkg::ERR_W-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tgt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [tgt_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tgt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int NGAIN = 3;
  localparam int GW = tgt_pkg::GAIN_W;
  localparam int SW = tgt_pkg::SUM_W;
  localparam int EW = tgt_pkg::ERR_W;
  localparam int PAD_LO = 3 * GW + SW;
  localparam logic [SW-1:0] SUM_CAP = '1;
  localparam logic [GW-1:0] GAIN_CAP = '1;

  logic [tgt_pkg::TL_W-1:0] len_reg;
  tgt_pkg::phase_t          stage;
  int                       focus;
  logic [GW-1:0]            best_g [NGAIN];
  logic [GW-1:0]            try_g  [NGAIN];
  logic [GW-1:0]            step_g [NGAIN];
  logic [SW-1:0]            run_sum;
  logic [SW-1:0]            best_sum;
  logic [tgt_pkg::TL_W-1:0] taken;
  tgt_pkg::result_t         gains_due [$];
  tgt_pkg::result_t         head;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic void reset_tuner();
    len_reg = tgt_pkg::TL_RESET;
    for (int g = 0; g < NGAIN; g++) begin
      best_g[g] = tgt_pkg::init_gain(g);
      try_g[g]  = tgt_pkg::init_gain(g);
      step_g[g] = tgt_pkg::init_step(g);
    end
    stage = tgt_pkg::PH_FIRST;
    focus = 0;
    run_sum = '0;
    best_sum = '0;
    taken = '0;
  endfunction

  // Starting values only reach the live state while the first trial runs.
  function automatic void load_reg(input logic [tgt_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [tgt_pkg::CFG_DATA_W-1:0] val);
    int g;
    if (idx == tgt_pkg::REG_TRIAL_LENGTH) begin
      len_reg = val[tgt_pkg::TL_W-1:0];
    end else if (stage == tgt_pkg::PH_FIRST) begin
      case (idx)
        tgt_pkg::REG_INIT_KP, tgt_pkg::REG_INIT_KI, tgt_pkg::REG_INIT_KD: begin
          g = int'(idx - tgt_pkg::REG_INIT_KP);
          best_g[g] = val;
          try_g[g] = val;
        end
        tgt_pkg::REG_INIT_STEP_P, tgt_pkg::REG_INIT_STEP_I, tgt_pkg::REG_INIT_STEP_D: begin
          g = int'(idx - tgt_pkg::REG_INIT_STEP_P);
          step_g[g] = val;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void launch_trial(input tgt_pkg::phase_t next);
    logic [GW:0] wide;
    for (int g = 0; g < NGAIN; g++) try_g[g] = best_g[g];
    stage = next;
    if (next == tgt_pkg::PH_INC) begin
      focus = (focus + 1) % NGAIN;
      wide = {1'b0, best_g[focus]} + {1'b0, step_g[focus]};
      try_g[focus] = wide[GW] ? GAIN_CAP : wide[GW-1:0];
    end else begin
      try_g[focus] = (best_g[focus] > step_g[focus]) ? best_g[focus] - step_g[focus] : '0;
    end
  endfunction

  function automatic void twiddle_update(input logic [EW-1:0] raw);
    logic [EW:0]       mag;
    logic [SW:0]       acc;
    logic [35:0]       scaled;
    logic [SW-1:0]     closed;
    bit                won;
    tgt_pkg::result_t  r;
    mag = raw[EW-1] ? -{raw[EW-1], raw} : {1'b0, raw};
    acc = run_sum + mag * mag;
    run_sum = acc[SW] ? SUM_CAP : acc[SW-1:0];
    taken = taken + 1'b1;
    if (taken != len_reg) return;

    closed = run_sum;
    won = 1'b0;
    if (stage == tgt_pkg::PH_FIRST) begin
      won = 1'b1;
      focus = 0;
      best_sum = closed;
      launch_trial(tgt_pkg::PH_INC);
    end else if (best_sum > closed) begin
      won = 1'b1;
      scaled = step_g[focus] * 36'd11 / 36'd10;
      step_g[focus] = (scaled[35:GW] != '0) ? GAIN_CAP : scaled[GW-1:0];
      for (int g = 0; g < NGAIN; g++) best_g[g] = try_g[g];
      best_sum = closed;
      launch_trial(tgt_pkg::PH_INC);
    end else if (stage == tgt_pkg::PH_INC) begin
      launch_trial(tgt_pkg::PH_DEC);
    end else begin
      scaled = step_g[focus] * 36'd9 / 36'd10;
      step_g[focus] = scaled[GW-1:0];
      launch_trial(tgt_pkg::PH_INC);
    end
    run_sum = '0;
    taken = '0;

    r.gain_p = try_g[0];
    r.gain_i = try_g[1];
    r.gain_d = try_g[2];
    r.trial_error = closed;
    r.improved = won;
    gains_due.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_tuner();
      gains_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) twiddle_update(in_tdata);
      if (out_tvalid && out_tready) begin
        if (gains_due.size() == 0) begin
          $error("result word arrived with no result expected");
          mismatches++;
        end else begin
          head = gains_due.pop_front();
          check_field("gain_p", head.gain_p, out_tdata[GW-1:0]);
          check_field("gain_i", head.gain_i, out_tdata[2*GW-1:GW]);
          check_field("gain_d", head.gain_d, out_tdata[3*GW-1:2*GW]);
          check_field("trial_error", head.trial_error, out_tdata[PAD_LO-1:3*GW]);
          check_field("improved", head.improved, out_tuser[0]);
          check_field("tdata padding", '0, out_tdata[tgt_pkg::OUT_DATA_W-1:PAD_LO]);
        end
      end
    end
    outstanding <= gains_due.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the twiddle gain tuner testbench: clock, reset, stimulus, pacing and verdict.
// Depends on tgt_pkg, the twiddle_gain_tuner RTL and the tgt_checker module.
module tb_top;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS = 680;
  localparam int EW = tgt_pkg::ERR_W;
  localparam int CIW = tgt_pkg::CFG_IDX_W;
  localparam int CDW = tgt_pkg::CFG_DATA_W;
  localparam logic [CIW-1:0] REG_SPARE = 3'd7;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [EW-1:0]                     in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [tgt_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic [tgt_pkg::OUT_USER_W-1:0]    out_tuser;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CIW-1:0]                    cfg_index = '0;
  logic [CDW-1:0]                    cfg_data = '0;

  int              mismatches;
  int              outstanding;
  int              cycles = 0;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  int              rx_hold = 0;
  int              rx_roll;

  always #5 clk = ~clk;

  twiddle_gain_tuner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tgt_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result consumer: mostly ready, short stalls, now and then a long one.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_quiet || rx_roll < 60) begin
        out_tready <= 1'b1;
        rx_hold <= $urandom_range(0, 7);
      end else if (rx_roll < 92) begin
        out_tready <= 1'b0;
        rx_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        rx_hold <= $urandom_range(10, 60);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [EW-1:0] draw_error();
    int roll;
    logic [EW-1:0] v;
    roll = $urandom_range(0, 9);
    case (roll)
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = '0;
      3, 4, 5: v = EW'($urandom);
      default: begin
        v = EW'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_error(input logic [EW-1:0] val);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every expected result word has been taken,
  // then idle for the settling time before going on.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int trials;
    int span;
    int roll;
    logic [CDW-1:0] val;
    sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // First trial: starting values written at their extremes, then replaced
    // part way through the trial, plus a write to an index with no register.
    write_reg(tgt_pkg::REG_TRIAL_LENGTH, 32'd4);
    write_reg(tgt_pkg::REG_INIT_KP, '0);
    write_reg(tgt_pkg::REG_INIT_KI, '1);
    write_reg(tgt_pkg::REG_INIT_KD, '0);
    write_reg(tgt_pkg::REG_INIT_STEP_P, '1);
    write_reg(tgt_pkg::REG_INIT_STEP_I, '0);
    write_reg(tgt_pkg::REG_INIT_STEP_D, '0);
    write_reg(REG_SPARE, $urandom);
    send_error(16'h8000);
    send_error(16'h7FFF);
    drain_results();
    write_reg(tgt_pkg::REG_INIT_KP, 32'hFFFF_FF00);
    write_reg(tgt_pkg::REG_INIT_KI, 32'h0000_0010);
    write_reg(tgt_pkg::REG_INIT_KD, 32'h0100_0000);
    write_reg(tgt_pkg::REG_INIT_STEP_P, 32'hF000_0000);
    write_reg(tgt_pkg::REG_INIT_STEP_I, 32'h8000_0000);
    write_reg(tgt_pkg::REG_INIT_STEP_D, 32'hFFFF_FFFF);
    send_error(16'h0001);
    send_error(16'hFFFF);
    drain_results();

    // One word per trial walks through improve, failed increase and failed decrease.
    write_reg(tgt_pkg::REG_TRIAL_LENGTH, 32'd1);
    send_error(16'h0000);
    send_error(16'h0000);
    send_error(16'h0000);
    send_error(16'h8000);
    send_error(16'h7FFF);
    send_error(16'hFFFF);
    rx_quiet = 1'b1;
    send_error(16'h0001);
    send_error(16'h0000);
    send_error(16'h8001);
    send_error(16'h00FF);
    drain_results();
    rx_quiet = 1'b0;
    send_error(16'hFF01);
    send_error(16'h0100);
    send_error(16'h5555);
    send_error(16'hAAAA);
    send_error(16'h0000);
    send_error(16'h0000);
    drain_results();

    // Random phases, each with its own trial length and pacing.
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) span = $urandom_range(1, 6);
      else if (roll < 95) span = $urandom_range(7, 40);
      else span = $urandom_range(41, 120);
      write_reg(tgt_pkg::REG_TRIAL_LENGTH, CDW'(span));
      if ($urandom_range(0, 2) == 0) begin
        roll = $urandom_range(0, 3);
        val = (roll == 0) ? '0 : (roll == 1) ? '1 : CDW'($urandom);
        write_reg(CIW'(tgt_pkg::REG_INIT_KP + $urandom_range(0, 5)), val);
      end
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      trials = (70 / span > 1) ? $urandom_range(1, 70 / span) : 1;
      for (int t = 0; t < trials; t++) begin
        for (int i = 0; i < span; i++) send_error(draw_error());
        sent += span;
        if ($urandom_range(0, 19) == 0) drain_results();
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
